@@ rtl/core/key_click_hold_classifier_core_defines.svh @@
// Assertion macros for the key click/hold classifier core.
// No dependencies; included by the top level only.
`ifndef KEY_CLICK_HOLD_CLASSIFIER_CORE_DEFINES_SVH
`define KEY_CLICK_HOLD_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KCHC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define KCHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/kchc_pkg.sv @@
// Shared types and constants for the key click/hold classifier core.
// No dependencies; imported by every module of the core.
package kchc_pkg;

   localparam int KEY_FIELD_W      = 8;
   localparam int NUM_KEYS_DEF     = 8;
   localparam int HOLD_W           = 16;
   localparam int INTERVAL_W       = 12;
   localparam int TICK_W           = 8;
   localparam int CSR_ADDR_W       = 4;
   localparam int CSR_DATA_W       = 32;
   localparam int REG_INDEX_W      = 2;

   localparam logic [INTERVAL_W-1:0] INTERVAL_CLAMP = 12'd3000;
   localparam logic [HOLD_W-1:0]     HOLD_MAX       = 16'hFFFF;

   // reset values of the config registers
   localparam logic                  MCE_RESET       = 1'b0;
   localparam logic [HOLD_W-1:0]     HOLD_THR_RESET  = 16'd1000;
   localparam logic [INTERVAL_W-1:0] IVL_THR_RESET   = 12'd300;
   localparam logic [TICK_W-1:0]     TICK_RESET      = 8'd10;

   // register indexes (byte address / 4)
   localparam logic [REG_INDEX_W-1:0] REG_MULTI_CLICK_ENABLE = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_HOLD_THRESHOLD     = 2'd1;
   localparam logic [REG_INDEX_W-1:0] REG_INTERVAL_THRESHOLD = 2'd2;
   localparam logic [REG_INDEX_W-1:0] REG_TICK_MS            = 2'd3;

   typedef struct packed {
      logic                  multi_click_enable;
      logic [HOLD_W-1:0]     hold_limit;
      logic [INTERVAL_W-1:0] gap_limit;
      logic [TICK_W-1:0]     tick_ms;
   } kchc_cfg_type;

   typedef struct packed {
      logic press;
      logic hold;
      logic multi;
   } kchc_flags_type;

   typedef enum logic [2:0] {
      PHASE_NORMAL = 3'b001,
      PHASE_WAIT   = 3'b010,
      PHASE_SECOND = 3'b100
   } kchc_phase_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_PRESS = 2'd1,
      EV_HOLD  = 2'd2,
      EV_MULTI = 2'd3
   } kchc_event_type;

endpackage

@@ rtl/core/key_click_hold_classifier_core.sv @@
// Key click/hold classifier; rsp_valid is driven by the result register.
// Throughput one item per cycle unless rsp_stall: input register, one pass through
// the key lanes, result register; the lane state update sits in that single pass.
// Reset (synchronous, active high) empties both stages, loads config defaults
// (multi-click off, hold 1000, interval 300, tick 10) and releases every key.
// Depends on kchc_pkg, kchc_csr, kchc_lane and the core defines header.
`include "key_click_hold_classifier_core_defines.svh"

module key_click_hold_classifier_core
   import kchc_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   // scan samples, active low, one bit per key
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KEY_FIELD_W-1:0] req_first_sample,
   input  logic [KEY_FIELD_W-1:0] req_second_sample,

   // per-tick classification flags
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KEY_FIELD_W-1:0] rsp_press_flags,
   output logic [KEY_FIELD_W-1:0] rsp_hold_flags,
   output logic [KEY_FIELD_W-1:0] rsp_multi_click_flags,

   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   kchc_cfg_type cfg;

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [KEY_FIELD_W-1:0] s1_first_ff, s1_second_ff;

   // result stage
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KEY_FIELD_W-1:0] press_ff, hold_ff, multi_ff;

   logic out_free;   // result register can take a new item this cycle
   logic advance;    // item in the input stage is classified this cycle
   logic req_accept;

   logic [NUM_KEYS-1:0]    level_vec;
   kchc_flags_type         lane_flags [NUM_KEYS];
   logic [KEY_FIELD_W-1:0] press_vec, hold_vec, multi_vec;
   logic [KEY_FIELD_W-1:0] overlap;  // keys with more than one flag in the result

   kchc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: stall only when the input stage is full and cannot move on
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_first_ff  <= req_first_sample;
         s1_second_ff <= req_second_sample;
      end
      if (advance) begin
         press_ff <= press_vec;
         hold_ff  <= hold_vec;
         multi_ff <= multi_vec;
      end
   end

   // Key level: pressed (0) only when both samples are low. Keys past the
   // sample width have no input and read as pressed.
   for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
      if (g < KEY_FIELD_W) begin : g_wired
         assign level_vec[g] = s1_first_ff[g] | s1_second_ff[g];
      end else begin : g_unwired
         assign level_vec[g] = 1'b0;
      end

      kchc_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .level   (level_vec[g]),
         .cfg     (cfg),
         .flags   (lane_flags[g])
      );
   end

   // Gather flags into the fixed-width result fields; lanes past the field
   // width are dropped, missing lanes read as zero.
   for (genvar g = 0; g < KEY_FIELD_W; g++) begin : g_flags
      if (g < NUM_KEYS) begin : g_present
         assign press_vec[g] = lane_flags[g].press;
         assign hold_vec[g]  = lane_flags[g].hold;
         assign multi_vec[g] = lane_flags[g].multi;
      end else begin : g_absent
         assign press_vec[g] = 1'b0;
         assign hold_vec[g]  = 1'b0;
         assign multi_vec[g] = 1'b0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_press_flags       = press_ff;
   assign rsp_hold_flags        = hold_ff;
   assign rsp_multi_click_flags = multi_ff;

   assign overlap = (press_ff & hold_ff) | (press_ff & multi_ff) | (hold_ff & multi_ff);

   // A key reports at most one event per tick.
   `KCHC_ASSERT_SAME(a_one_event, clock, reset, rsp_valid_ff, overlap == '0, "key has two events")

   // An item in the input stage reaches the result register unless it is blocked.
   `KCHC_ASSERT_NEXT(a_stage_moves, clock, reset, advance, rsp_valid_ff, "item lost in pipe")

endmodule

@@ rtl/core/kchc_csr.sv @@
// Configuration register file of the classifier, APB-style slave.
// Depends on kchc_pkg.
module kchc_csr
   import kchc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output kchc_cfg_type          cfg
);

   kchc_cfg_type            cfg_ff, cfg_in;
   logic [REG_INDEX_W-1:0]  index;
   logic                    wr_en;

   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_MULTI_CLICK_ENABLE: cfg_in.multi_click_enable = csr_pwdata[0];
            REG_HOLD_THRESHOLD:     cfg_in.hold_limit         = csr_pwdata[HOLD_W-1:0];
            REG_INTERVAL_THRESHOLD: cfg_in.gap_limit          = csr_pwdata[INTERVAL_W-1:0];
            REG_TICK_MS:            cfg_in.tick_ms            = csr_pwdata[TICK_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_MULTI_CLICK_ENABLE:
            csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.multi_click_enable};
         REG_HOLD_THRESHOLD:
            csr_prdata = {{(CSR_DATA_W-HOLD_W){1'b0}}, cfg_ff.hold_limit};
         REG_INTERVAL_THRESHOLD:
            csr_prdata = {{(CSR_DATA_W-INTERVAL_W){1'b0}}, cfg_ff.gap_limit};
         REG_TICK_MS:
            csr_prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, cfg_ff.tick_ms};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.multi_click_enable <= MCE_RESET;
         cfg_ff.hold_limit         <= HOLD_THR_RESET;
         cfg_ff.gap_limit          <= IVL_THR_RESET;
         cfg_ff.tick_ms            <= TICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/kchc_lane.sv @@
// One key's lane: edge detect, hold/interval timers, click phase tracking.
// Depends on kchc_pkg.
module kchc_lane
   import kchc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           level,
   input  kchc_cfg_type   cfg,
   output kchc_flags_type flags
);

   logic                  prev_ff, prev_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic [INTERVAL_W-1:0] ivl_ff, ivl_in;
   kchc_phase_type        phase_ff, phase_in;

   logic                  is_down, is_up, is_held, is_idle, short_press;
   logic [HOLD_W:0]       hold_sum;
   logic [INTERVAL_W:0]   ivl_sum;
   kchc_event_type        ev;

   always_comb begin
      is_down  = prev_ff && !level;
      is_up    = !prev_ff && level;
      is_held  = !prev_ff && !level;
      is_idle  = prev_ff && level;
      hold_sum = {1'b0, hold_ff} + {{(HOLD_W-TICK_W+1){1'b0}}, cfg.tick_ms};
      ivl_sum  = {1'b0, ivl_ff} + {{(INTERVAL_W-TICK_W+1){1'b0}}, cfg.tick_ms};
      prev_in  = level;

      // timers: scan step
      hold_in = hold_ff;
      ivl_in  = ivl_ff;
      if (is_down) begin
         hold_in = '0;
      end else if (is_up) begin
         ivl_in = '0;
      end else if (is_held) begin
         hold_in = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];
      end else if (is_idle) begin
         // clamped value plus one tick stays below 4096
         ivl_in = (ivl_ff >= INTERVAL_CLAMP) ? INTERVAL_CLAMP : ivl_sum[INTERVAL_W-1:0];
      end

      // classify step, later rules override earlier ones
      short_press = hold_in < cfg.hold_limit;
      phase_in    = phase_ff;
      ev          = EV_NONE;
      if (is_up && !short_press) begin
         ev = EV_HOLD;
      end
      if (is_up && short_press) begin
         if (!cfg.multi_click_enable) begin
            ev = EV_PRESS;
         end else if (phase_in == PHASE_NORMAL) begin
            phase_in = PHASE_WAIT;
         end
      end
      if (cfg.multi_click_enable) begin
         if (phase_in == PHASE_WAIT && is_down && ivl_in < cfg.gap_limit) begin
            phase_in = PHASE_SECOND;
         end
         if (phase_in == PHASE_WAIT && ivl_in > cfg.gap_limit) begin
            ev       = EV_PRESS;
            phase_in = PHASE_NORMAL;
         end
         if (phase_in == PHASE_SECOND && is_up && short_press) begin
            ev       = EV_MULTI;
            phase_in = PHASE_NORMAL;
         end
      end

      flags.press = (ev == EV_PRESS);
      flags.hold  = (ev == EV_HOLD);
      flags.multi = (ev == EV_MULTI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b1;
         hold_ff  <= '0;
         ivl_ff   <= '0;
         phase_ff <= PHASE_NORMAL;
      end else if (advance) begin
         prev_ff  <= prev_in;
         hold_ff  <= hold_in;
         ivl_ff   <= ivl_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for key_click_hold_classifier_core: scan items, CSR writes, flag checks.
// Depends on kchc_pkg and the core RTL. It predicts the flags of each scan tick on its own and
// compares every result against them.
module tb;
   import kchc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;          // margin after the last result is checked

   typedef struct packed {
      logic [KEY_FIELD_W-1:0] press;
      logic [KEY_FIELD_W-1:0] hold;
      logic [KEY_FIELD_W-1:0] multi;
   } tick_flags_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic [KEY_FIELD_W-1:0] req_first_sample  = '1;
   logic [KEY_FIELD_W-1:0] req_second_sample = '1;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KEY_FIELD_W-1:0] rsp_press_flags;
   logic [KEY_FIELD_W-1:0] rsp_hold_flags;
   logic [KEY_FIELD_W-1:0] rsp_multi_click_flags;

   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Flag predictor state: config copy plus per-key level, timers and click phase.
   kchc_cfg_type           model_cfg;
   logic [KEY_FIELD_W-1:0] key_level;
   logic [HOLD_W-1:0]      hold_ms     [KEY_FIELD_W];
   logic [INTERVAL_W-1:0]  gap_ms      [KEY_FIELD_W];
   kchc_phase_type         click_state [KEY_FIELD_W];

   // Flags predicted for accepted scan items, oldest first.
   tick_flags_type pending_flags[$];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // Random key activity generator: current level and ticks left in the run.
   logic [KEY_FIELD_W-1:0] gen_level = '1;
   int                     gen_left [KEY_FIELD_W];

   always #6 clock = ~clock;

   key_click_hold_classifier_core u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_first_sample      (req_first_sample),
      .req_second_sample     (req_second_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_press_flags       (rsp_press_flags),
      .rsp_hold_flags        (rsp_hold_flags),
      .rsp_multi_click_flags (rsp_multi_click_flags),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   // One scan tick: scan updates the timers, then classify derives the event per key.
   function automatic tick_flags_type classify_tick(input logic [KEY_FIELD_W-1:0] first_s,
                                                    input logic [KEY_FIELD_W-1:0] second_s);
      tick_flags_type         flags;
      logic [KEY_FIELD_W-1:0] level;
      logic                   down, up, held, short_press;
      logic [HOLD_W:0]        grown;
      kchc_event_type         ev;
      flags = '0;
      // pressed only when both samples read low
      level = first_s | second_s;
      for (int k = 0; k < KEY_FIELD_W; k++) begin
         down = key_level[k] & ~level[k];
         up   = ~key_level[k] & level[k];
         held = ~key_level[k] & ~level[k];
         ev   = EV_NONE;

         if (down) begin
            hold_ms[k] = '0;
         end else if (up) begin
            gap_ms[k] = '0;
         end else if (held) begin
            grown = {1'b0, hold_ms[k]} + (HOLD_W+1)'(model_cfg.tick_ms);
            hold_ms[k] = grown[HOLD_W] ? HOLD_MAX : grown[HOLD_W-1:0];
         end else if (gap_ms[k] >= INTERVAL_CLAMP) begin
            gap_ms[k] = INTERVAL_CLAMP;
         end else begin
            // may overshoot the clamp by one tick
            gap_ms[k] = gap_ms[k] + INTERVAL_W'(model_cfg.tick_ms);
         end
         key_level[k] = level[k];

         short_press = hold_ms[k] < model_cfg.hold_limit;
         if (up && !short_press)
            ev = EV_HOLD;
         if (up && short_press) begin
            if (!model_cfg.multi_click_enable)
               ev = EV_PRESS;
            else if (click_state[k] == PHASE_NORMAL)
               click_state[k] = PHASE_WAIT;
         end
         if (model_cfg.multi_click_enable) begin
            if (click_state[k] == PHASE_WAIT && down &&
                gap_ms[k] < model_cfg.gap_limit)
               click_state[k] = PHASE_SECOND;
            // second click never came: fall back to a single press
            if (click_state[k] == PHASE_WAIT && gap_ms[k] > model_cfg.gap_limit) begin
               ev = EV_PRESS;
               click_state[k] = PHASE_NORMAL;
            end
            if (click_state[k] == PHASE_SECOND && up && short_press) begin
               ev = EV_MULTI;
               click_state[k] = PHASE_NORMAL;
            end
         end

         case (ev)
            EV_PRESS: flags.press[k] = 1'b1;
            EV_HOLD:  flags.hold[k]  = 1'b1;
            EV_MULTI: flags.multi[k] = 1'b1;
            default: ;
         endcase
      end
      return flags;
   endfunction

   // Present one scan item, wait for acceptance, record its predicted flags.
   // Valid stays high on return; the next call or drain_results sets it in the same step.
   task automatic send_scan(input logic [KEY_FIELD_W-1:0] first_s,
                            input logic [KEY_FIELD_W-1:0] second_s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_first_sample  <= first_s;
      req_second_sample <= second_s;
      do @(posedge clock); while (req_stall);
      pending_flags.push_back(classify_tick(first_s, second_s));
   endtask

   task automatic send_level(input logic [KEY_FIELD_W-1:0] level, input int ticks);
      repeat (ticks) send_scan(level, level);
   endtask

   // Stop sending and wait until every predicted item has come back.
   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read(input logic [REG_INDEX_W-1:0] index);
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_MULTI_CLICK_ENABLE: want = CSR_DATA_W'(model_cfg.multi_click_enable);
         REG_HOLD_THRESHOLD:     want = CSR_DATA_W'(model_cfg.hold_limit);
         REG_INTERVAL_THRESHOLD: want = CSR_DATA_W'(model_cfg.gap_limit);
         default:                want = CSR_DATA_W'(model_cfg.tick_ms);
      endcase
      if (csr_prdata !== want) begin
         $display("%0t csr reg %0d: expected %08h, actual %08h", $time, index, want, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write only with the core idle, then read the register back.
   task automatic csr_write(input logic [REG_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // wide values land masked to the register width
      case (index)
         REG_MULTI_CLICK_ENABLE: model_cfg.multi_click_enable = value[0];
         REG_HOLD_THRESHOLD:     model_cfg.hold_limit         = value[HOLD_W-1:0];
         REG_INTERVAL_THRESHOLD: model_cfg.gap_limit          = value[INTERVAL_W-1:0];
         default:                model_cfg.tick_ms            = value[TICK_W-1:0];
      endcase
      @(posedge clock);
      csr_read(index);
   endtask

   function automatic int run_length(input logic pressed);
      int pick;
      pick = $urandom_range(99);
      if (pressed)
         return (pick < 60) ? $urandom_range(1, 6) :
                (pick < 85) ? $urandom_range(7, 40) : $urandom_range(40, 150);
      // short gaps give double clicks, long ones let the wait expire
      return (pick < 50) ? $urandom_range(1, 4) :
             (pick < 80) ? $urandom_range(5, 30) : $urandom_range(30, 120);
   endfunction

   // Mostly well-formed press/release runs per key; some bounce and fully random noise.
   task automatic next_random_scan(output logic [KEY_FIELD_W-1:0] first_s,
                                   output logic [KEY_FIELD_W-1:0] second_s);
      if ($urandom_range(9) == 0) begin
         first_s  = KEY_FIELD_W'($urandom);
         second_s = KEY_FIELD_W'($urandom);
      end else begin
         for (int k = 0; k < KEY_FIELD_W; k++) begin
            if (gen_left[k] <= 0) begin
               gen_level[k] = ~gen_level[k];
               gen_left[k]  = run_length(!gen_level[k]);
            end
            gen_left[k]--;
            if (!gen_level[k]) begin
               first_s[k]  = 1'b0;
               second_s[k] = ($urandom_range(49) == 0);   // contact bounce
            end else begin
               first_s[k]  = 1'($urandom_range(1));
               second_s[k] = first_s[k] ? 1'($urandom_range(1)) : 1'b1;
            end
         end
      end
   endtask

   // Result checker: every accepted result against the oldest prediction.
   always @(posedge clock) begin : check_results
      tick_flags_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_flags.size() == 0) begin
            $display("%0t unexpected item: expected none, actual %02h/%02h/%02h", $time,
                     rsp_press_flags, rsp_hold_flags, rsp_multi_click_flags);
            error_count++;
         end else begin
            want = pending_flags.pop_front();
            if (rsp_press_flags !== want.press) begin
               $display("%0t press_flags: expected %02h, actual %02h",
                        $time, want.press, rsp_press_flags);
               error_count++;
            end
            if (rsp_hold_flags !== want.hold) begin
               $display("%0t hold_flags: expected %02h, actual %02h",
                        $time, want.hold, rsp_hold_flags);
               error_count++;
            end
            if (rsp_multi_click_flags !== want.multi) begin
               $display("%0t multi_click_flags: expected %02h, actual %02h",
                        $time, want.multi, rsp_multi_click_flags);
               error_count++;
            end
         end
      end
   end

   // Receiver backpressure.
   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_reset_values;
      csr_read(REG_MULTI_CLICK_ENABLE);
      csr_read(REG_HOLD_THRESHOLD);
      csr_read(REG_INTERVAL_THRESHOLD);
      csr_read(REG_TICK_MS);
   endtask

   // Sample combining and plain press/release with default config.
   task automatic test_scan_levels;
      send_scan(8'hFF, 8'hFF);
      send_scan(8'h00, 8'h00);   // all down
      send_scan(8'h00, 8'h00);   // all held
      send_scan(8'hFF, 8'hFF);   // all up: press on every key
      send_scan(8'h00, 8'hFF);   // one sample low only reads released
      send_scan(8'hFF, 8'h00);
      send_scan(8'hAA, 8'h55);
      send_scan(8'h0F, 8'h0F);   // upper keys down
      send_scan(8'h0F, 8'h00);
      send_scan(8'hF0, 8'hF0);   // lower down, upper up
      send_scan(8'hFF, 8'hFF);
   endtask

   // Release at and below the hold threshold, and a zero threshold.
   task automatic test_long_press;
      csr_write(REG_HOLD_THRESHOLD, 20);
      send_level(8'hFE, 3);      // hold time reaches exactly 20
      send_level(8'hFF, 1);
      send_level(8'hFD, 2);      // 10 ms: short
      send_level(8'hFF, 1);
      csr_write(REG_HOLD_THRESHOLD, 0);
      send_level(8'h7F, 1);      // every release is a hold now
      send_level(8'hFF, 1);
      csr_write(REG_HOLD_THRESHOLD, 1000);
   endtask

   task automatic test_multi_click;
      csr_write(REG_MULTI_CLICK_ENABLE, 1);
      csr_write(REG_TICK_MS, 100);
      // double click on key 0
      send_level(8'hFE, 1);
      send_level(8'hFF, 1);
      send_level(8'hFE, 1);
      send_level(8'hFF, 1);
      // single click on key 1; gap hits 300 (no event), then 400 (press)
      send_level(8'hFD, 1);
      send_level(8'hFF, 5);
   endtask

   // Masked wide writes, hold saturation, interval clamp and a frozen tick.
   task automatic test_extremes;
      csr_write(REG_MULTI_CLICK_ENABLE, 32'hFFFF_FFFF);
      csr_write(REG_HOLD_THRESHOLD, 32'hFFFF_FFFF);
      csr_write(REG_INTERVAL_THRESHOLD, 32'hFFFF_FFFF);
      csr_write(REG_TICK_MS, 32'hFFFF_FFFF);
      send_level(8'hF7, 260);    // hold time saturates at the max
      send_level(8'hFF, 14);     // saturated hold counts as hold; gap clamps
      csr_write(REG_INTERVAL_THRESHOLD, 3000);
      send_level(8'hEF, 1);
      send_level(8'hFF, 14);     // gap overshoots 3000 once: press
      csr_write(REG_TICK_MS, 0);
      send_level(8'hDF, 3);
      send_level(8'hFF, 3);      // timers frozen, wait never expires
      csr_write(REG_TICK_MS, 255);
      send_level(8'hFF, 14);
   endtask

   task automatic run_random_phase(input int items, input int idle_pct, input int stall_v);
      int tick_v, hold_v, gap_v;
      logic [KEY_FIELD_W-1:0] first_s, second_s;
      tick_v = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 1 : 255) : $urandom_range(1, 40);
      hold_v = ($urandom_range(9) == 0) ? 0 : tick_v * $urandom_range(1, 25);
      gap_v  = tick_v * $urandom_range(0, 10);
      if (gap_v > 3000)
         gap_v = 3000;
      csr_write(REG_MULTI_CLICK_ENABLE, CSR_DATA_W'($urandom_range(3) != 0));
      csr_write(REG_HOLD_THRESHOLD, hold_v);
      csr_write(REG_INTERVAL_THRESHOLD, gap_v);
      csr_write(REG_TICK_MS, tick_v);
      send_idle_pct = idle_pct;
      stall_pct     = stall_v;
      repeat (items) begin
         // occasionally let the pipe run dry mid-stream
         if ($urandom_range(199) == 0)
            drain_results();
         next_random_scan(first_s, second_s);
         send_scan(first_s, second_s);
      end
      drain_results();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   task automatic test_random;
      repeat (2) begin
         run_random_phase(200, 0, 0);
         run_random_phase(200, 80, 0);
         run_random_phase(200, 0, 80);
         run_random_phase(200, 7, 7);
      end
   endtask

   initial begin
      model_cfg = '{MCE_RESET, HOLD_THR_RESET, IVL_THR_RESET, TICK_RESET};
      key_level = '1;
      for (int k = 0; k < KEY_FIELD_W; k++) begin
         hold_ms[k]     = '0;
         gap_ms[k]      = '0;
         click_state[k] = PHASE_NORMAL;
         gen_left[k]    = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_scan_levels();
      test_long_press();
      test_multi_click();
      test_extremes();
      test_random();

      drain_results();
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
